### design/pfde_pkg.sv
// ----------------------------------------------------------------------------
// pfde_pkg - shared types and constants for the page frame store draw engine
// Opcodes, coordinate width, page geometry and the pixel lookup result type.
// ----------------------------------------------------------------------------
package pfde_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int PAGE_ROWS         = 8;
  localparam int BYTE_W            = 8;
  // signed working width for columns/rows; holds -1024 .. 1023
  localparam int COORD_W           = 11;

  localparam logic [BYTE_W-1:0] CLEAR_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] FILL_BYTE  = 8'hFF;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_FILL  = 3'd1,
    OP_PIXEL = 3'd2,
    OP_HLINE = 3'd3,
    OP_VLINE = 3'd4,
    OP_RECT  = 3'd5,
    OP_READ  = 3'd6
  } op_t;

  // pixel lookup status: on screen flag and bit select within the byte
  typedef struct packed {
    logic              hit;
    logic [BYTE_W-1:0] mask;
  } pix_hit_t;

endpackage

### design/pfde_if.sv
// ----------------------------------------------------------------------------
// pfde_in_if / pfde_out_if - valid/ready channels of the draw engine
// Command beats in, read-back beats out.
// ----------------------------------------------------------------------------
interface pfde_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic signed [8:0] x;
  logic signed [8:0] y;
  logic [7:0]        width;
  logic [7:0]        height;
  logic              color;

  modport source (output valid, op, x, y, width, height, color, input ready);
  modport sink   (input valid, op, x, y, width, height, color, output ready);
endinterface

interface pfde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       in_range;

  modport source (output valid, data, in_range, input ready);
  modport sink   (input valid, data, in_range, output ready);
endinterface

### design/pfde_addr_unit.sv
// ----------------------------------------------------------------------------
// pfde_addr_unit - shared pixel address unit
// Clips a column/row pair to the screen and forms byte address and bit mask.
// ----------------------------------------------------------------------------
module pfde_addr_unit
  import pfde_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int AW            = 10
) (
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  output logic [AW-1:0]      addr,
  output pix_hit_t           res
);

  logic [COORD_W-1:0] page;

  // sign bit set means negative; unsigned compare then handles the right and bottom edges
  assign res.hit = !col[COORD_W-1] && (col < COORD_W'(SCREEN_WIDTH)) &&
                   !row[COORD_W-1] && (row < COORD_W'(SCREEN_HEIGHT));

  assign page     = row >> 3;
  assign addr     = AW'(AW'(col) + AW'(AW'(page) * AW'(SCREEN_WIDTH)));
  assign res.mask = BYTE_W'(1) << row[2:0];

endmodule

### design/pfde_frame_mem.sv
// ----------------------------------------------------------------------------
// pfde_frame_mem - frame byte store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfde_frame_mem
  import pfde_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] store_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store_mem[rd_addr];
    end
  end

endmodule

### design/page_framebuffer_draw_engine_unit.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_unit - monochrome page frame store draw engine
// Clear/fill sweeps, pixel, line and rectangle drawing by read-modify-write
// through one shared address unit, and byte read-back.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                               | beats
//  ---------+-----+---------------------------------------+------------------
//  in_ch    | in  | op, x, y, width, height, color        | one per command
//  out_ch   | out | data, in_range                        | one per read op
//
//  Clear/fill write one byte a cycle over the whole store. Pixel, line and
//  rect read and write back each on-screen pixel; off-screen pixels get no
//  memory access; each segment ends with a check step. A read issues the
//  memory read, then loads the output register. Reset: a clearing pass of
//  all STORE_DEPTH bytes runs first; in_ch.ready stays low during it. A read
//  result waits in the output register; a further read stalls until it frees.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_unit
  import pfde_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pfde_in_if.sink     in_ch,
  pfde_out_if.source  out_ch
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_DEPTH = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_DEPTH);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,  // clearing pass after reset
    S_IDLE  = 6'b000010,
    S_SWEEP = 6'b000100,  // clear / fill
    S_STEP  = 6'b001000,  // next pixel of a segment, issue read
    S_WRITE = 6'b010000,  // merge bit, write back
    S_RDATA = 6'b100000   // read-back data ready, load output
  } state_t;

  // segment ids: top edge / hline, bottom edge, left edge / vline, right edge
  localparam logic [1:0] SEG_TOP   = 2'd0;
  localparam logic [1:0] SEG_BOT   = 2'd1;
  localparam logic [1:0] SEG_LEFT  = 2'd2;
  localparam logic [1:0] SEG_RIGHT = 2'd3;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     sweep_r, sweep_nxt;
  logic              fill_r, fill_nxt;
  logic [8:0]        x_r, x_nxt;
  logic [8:0]        y_r, y_nxt;
  logic [7:0]        w_r, w_nxt;
  logic [7:0]        h_r, h_nxt;
  logic              color_r, color_nxt;
  logic              pix_r, pix_nxt;
  logic [1:0]        seg_r, seg_nxt;
  logic [1:0]        last_r, last_nxt;
  logic [7:0]        step_r, step_nxt;
  logic [AW-1:0]     waddr_r, waddr_nxt;
  logic [BYTE_W-1:0] mask_r, mask_nxt;
  logic              rhit_r, rhit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_rng_r, out_rng_nxt;

  // segment descriptor
  logic [COORD_W-1:0] xe, ye, we, he;
  logic [COORD_W-1:0] col0, row0, col, row;
  logic [7:0]         seg_len;
  logic               horiz;

  // shared address unit and memory
  logic [AW-1:0]      pix_addr;
  pix_hit_t           pix;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [BYTE_W-1:0]  mem_wdata, mem_q;

  assign xe = {{(COORD_W-9){x_r[8]}}, x_r};
  assign ye = {{(COORD_W-9){y_r[8]}}, y_r};
  assign we = COORD_W'(w_r);
  assign he = COORD_W'(h_r);

  always_comb begin
    unique case (seg_r)
      SEG_TOP: begin
        col0 = xe; row0 = ye; seg_len = w_r; horiz = 1'b1;
      end
      SEG_BOT: begin
        col0 = xe; row0 = COORD_W'(ye + he - COORD_W'(1)); seg_len = w_r; horiz = 1'b1;
      end
      SEG_LEFT: begin
        col0 = xe; row0 = ye; seg_len = h_r; horiz = 1'b0;
      end
      default: begin
        col0 = COORD_W'(xe + we - COORD_W'(1)); row0 = ye; seg_len = h_r; horiz = 1'b0;
      end
    endcase
    if (pix_r) begin
      seg_len = 8'd1;
    end
    col = horiz ? COORD_W'(col0 + COORD_W'(step_r)) : col0;
    row = horiz ? row0 : COORD_W'(row0 + COORD_W'(step_r));
  end

  pfde_addr_unit #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .AW            (AW)
  ) u_addr (
    .col  (col),
    .row  (row),
    .addr (pix_addr),
    .res  (pix)
  );

  pfde_frame_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (pix_addr),
    .rd_data (mem_q)
  );

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.data     = out_data_r;
  assign out_ch.in_range = out_rng_r;

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    fill_nxt      = fill_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    color_nxt     = color_r;
    pix_nxt       = pix_r;
    seg_nxt       = seg_r;
    last_nxt      = last_r;
    step_nxt      = step_r;
    waddr_nxt     = waddr_r;
    mask_nxt      = mask_r;
    rhit_nxt      = rhit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_rng_nxt   = out_rng_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = waddr_r;
    mem_wdata     = fill_r ? FILL_BYTE : CLEAR_BYTE;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT, S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        if (sweep_r == AW'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          x_nxt     = in_ch.x;
          y_nxt     = in_ch.y;
          w_nxt     = in_ch.width;
          h_nxt     = in_ch.height;
          color_nxt = in_ch.color;
          step_nxt  = 8'd0;
          pix_nxt   = 1'b0;
          seg_nxt   = SEG_TOP;
          last_nxt  = SEG_TOP;
          sweep_nxt = '0;
          unique case (op_t'(in_ch.op))
            OP_CLEAR: begin
              fill_nxt  = 1'b0;
              state_nxt = S_SWEEP;
            end
            OP_FILL: begin
              fill_nxt  = 1'b1;
              state_nxt = S_SWEEP;
            end
            OP_PIXEL: begin
              pix_nxt   = 1'b1;
              state_nxt = S_STEP;
            end
            OP_HLINE: begin
              state_nxt = S_STEP;
            end
            OP_VLINE: begin
              seg_nxt   = SEG_LEFT;
              last_nxt  = SEG_LEFT;
              state_nxt = S_STEP;
            end
            OP_RECT: begin
              last_nxt  = SEG_RIGHT;
              state_nxt = S_STEP;
            end
            OP_READ: begin
              // top segment, step 0 puts (x, y) on the address unit
              pix_nxt   = 1'b1;
              state_nxt = S_RDATA;
            end
            default: ;  // unused opcode: dropped
          endcase
        end
      end

      S_STEP: begin
        if (step_r == seg_len) begin
          if (seg_r == last_r) begin
            state_nxt = S_IDLE;
          end else begin
            seg_nxt  = seg_r + 2'd1;
            step_nxt = 8'd0;
          end
        end else if (pix.hit) begin
          mem_re    = 1'b1;
          waddr_nxt = pix_addr;
          mask_nxt  = pix.mask;
          state_nxt = S_WRITE;
        end else begin
          step_nxt = step_r + 8'd1;
        end
      end

      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = color_r ? (mem_q | mask_r) : (mem_q & ~mask_r);
        step_nxt  = step_r + 8'd1;
        state_nxt = S_STEP;
      end

      S_RDATA: begin
        // first cycle here issues the read; data is loaded once the output
        // register is free (pix_r marks the address phase)
        if (pix_r) begin
          mem_re   = pix.hit;
          rhit_nxt = pix.hit;
          pix_nxt  = 1'b0;
        end else if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rhit_r ? mem_q : CLEAR_BYTE;
          out_rng_nxt   = rhit_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      fill_r      <= 1'b0;
      pix_r       <= 1'b0;
      seg_r       <= SEG_TOP;
      last_r      <= SEG_TOP;
      step_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      fill_r      <= fill_nxt;
      pix_r       <= pix_nxt;
      seg_r       <= seg_nxt;
      last_r      <= last_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    color_r    <= color_nxt;
    waddr_r    <= waddr_nxt;
    mask_r     <= mask_nxt;
    rhit_r     <= rhit_nxt;
    out_data_r <= out_data_nxt;
    out_rng_r  <= out_rng_nxt;
  end

endmodule
